FILE: rtl/olab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olab_pkg
// Shared constants for the linear RGB to OkLab pipeline: coefficient tables,
// internal widths and stage counts.
// ----------------------------------------------------------------------------
package olab_pkg;

  localparam int CHANNEL_BITS_DEF = 16;

  // Rescaled channel: unsigned fraction, 24 fraction bits, 1.0 reachable.
  localparam int CH_W    = 25;
  // Cone response: 40 fraction bits plus one integer bit.
  localparam int CONE_W  = 41;
  // Cube root: 20 fraction bits plus headroom.
  localparam int ROOT_W  = 22;
  localparam int REM_W   = 64;
  localparam int SQ_W    = 2 * ROOT_W;
  localparam int BIG_W   = SQ_W + 4;
  localparam int CBRT_STEPS = 22;

  // Lane stages: product, sum, then one per root digit.
  localparam int LANE_STAGES  = 2 + CBRT_STEPS;
  // Whole pipeline: channel register, lane stages, two merge stages.
  localparam int PIPE_STAGES  = 1 + LANE_STAGES + 2;

  localparam int LAB_COEF_W = 19;
  localparam int LAB_PROD_W = LAB_COEF_W + ROOT_W + 1;
  localparam int LAB_SUM_W  = LAB_PROD_W + 2;
  localparam int RND_W      = LAB_SUM_W - 20;

  localparam logic [15:0] CONE_COEF [3][3] = '{
    '{16'd27015, 16'd35149, 16'd3372},
    '{16'd13887, 16'd44610, 16'd7038},
    '{16'd5787,  16'd18463, 16'd41286}
  };

  localparam logic signed [LAB_COEF_W-1:0] LAB_COEF [3][3] = '{
    '{19'sd13792,  19'sd52011,   -19'sd267},
    '{19'sd129630, -19'sd159160, 19'sd29530},
    '{19'sd1698,   19'sd51300,   -19'sd52997}
  };

endpackage

FILE: rtl/linear_rgb_to_oklab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab
// Linear RGB pixel stream to OkLab, one pixel per clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one OkLab result per clock while the
// output is not stalled. Each channel is rescaled to a 24-bit fraction, three
// parallel lanes form the cone responses l, m and s and take their cube roots
// in a 22-stage digit pipeline (one root bit per stage), and the merge stages
// apply the second matrix, round half up and clamp L to 0..1-2^-16 and a, b
// to -0.5..0.5. Every stage holds its item independently, so a stalled
// output only backs up the pipeline once all stages are full; bubbles are
// squeezed out while the output waits.
// ----------------------------------------------------------------------------
module linear_rgb_to_oklab #(
  parameter int CHANNEL_BITS = olab_pkg::CHANNEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CHANNEL_BITS-1:0]  red_level,
  input  logic [CHANNEL_BITS-1:0]  green_level,
  input  logic [CHANNEL_BITS-1:0]  blue_level,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [15:0]              lightness,
  output logic signed [16:0]       green_red_axis,
  output logic signed [16:0]       blue_yellow_axis
);
  import olab_pkg::*;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] en;
  logic [CH_W-1:0]        ch_in [3];
  logic [CH_W-1:0]        ch    [3];
  logic [ROOT_W-1:0]      root  [3];

  // Stage k advances when it is empty or the stage after it advances.
  always_comb begin
    logic down;
    down = !out_stall;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || down;
      down  = en[k];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[PIPE_STAGES-1];

  // Advance the valid bits along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  olab_rescale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_r (.level(red_level),   .scaled(ch_in[0]));
  olab_rescale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_g (.level(green_level), .scaled(ch_in[1]));
  olab_rescale #(.CHANNEL_BITS(CHANNEL_BITS)) u_scale_b (.level(blue_level),  .scaled(ch_in[2]));

  // Hold the rescaled channels for the lanes.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ch <= ch_in;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    olab_lane #(.ROW(i)) u_lane (
      .clk  (clk),
      .ch   (ch),
      .en   (en[LANE_STAGES:1]),
      .root (root[i])
    );
  end

  olab_merge u_merge (
    .clk              (clk),
    .root             (root),
    .en               (en[PIPE_STAGES-1:PIPE_STAGES-2]),
    .lightness        (lightness),
    .green_red_axis   (green_red_axis),
    .blue_yellow_axis (blue_yellow_axis)
  );

  // Input is refused only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> &v)
    else $error("input stalled with a bubble in the pipeline");

  // A waiting result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("waiting result dropped");

  // Chroma stays inside the clamp limits.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (green_red_axis <= 17'sd32768 && green_red_axis >= -17'sd32768
                   && blue_yellow_axis <= 17'sd32768 && blue_yellow_axis >= -17'sd32768))
    else $error("chroma outside clamp range");

endmodule

FILE: rtl/olab_rescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olab_rescale
// Rescale one channel of full scale 2^N-1 to a 24-fraction-bit value,
// rounded to nearest, by folding the division by 2^N-1.
// ----------------------------------------------------------------------------
module olab_rescale #(
  parameter int CHANNEL_BITS = olab_pkg::CHANNEL_BITS_DEF
) (
  input  logic [CHANNEL_BITS-1:0] level,
  output logic [olab_pkg::CH_W-1:0] scaled
);
  import olab_pkg::*;

  localparam int N     = CHANNEL_BITS;
  localparam int MW    = N + 26;
  localparam int FOLDS = (25 + N - 1) / N + 2;
  localparam logic [MW-1:0] FULL = {{(MW-N){1'b0}}, {N{1'b1}}};

  always_comb begin
    logic [MW-1:0] m;
    logic [MW-1:0] q;
    logic [MW-1:0] hi;
    m = ({{(MW-N){1'b0}}, level} << 24) + (FULL >> 1);
    q = '0;
    // n = a*2^N + b = a*F + (a + b): accumulate a, keep folding the rest
    for (int k = 0; k < FOLDS; k++) begin
      hi = m >> N;
      q  = q + hi;
      m  = hi + (m & FULL);
    end
    if (m >= FULL) begin
      q = q + 1'b1;
    end
    scaled = q[CH_W-1:0];
  end

endmodule

FILE: rtl/olab_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olab_lane
// One cone lane: dot product with a row of the first matrix, then a
// pipelined floor cube root, one binary digit per stage.
// ----------------------------------------------------------------------------
module olab_lane #(
  parameter int ROW = 0
) (
  input  logic                              clk,
  input  logic [olab_pkg::CH_W-1:0]         ch [3],
  input  logic [olab_pkg::LANE_STAGES-1:0]  en,
  output logic [olab_pkg::ROOT_W-1:0]       root
);
  import olab_pkg::*;

  logic [CONE_W-1:0] prod [3];
  logic [CONE_W-1:0] acc;
  logic [REM_W-1:0]  rem_q [CBRT_STEPS];
  logic [ROOT_W-1:0] y_q   [CBRT_STEPS];
  logic [SQ_W-1:0]   sq_q  [CBRT_STEPS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= CONE_W'(CONE_COEF[ROW][j]) * CONE_W'(ch[j]);
      end
    end
    if (en[1]) begin
      acc <= prod[0] + prod[1] + prod[2];
    end
  end

  for (genvar k = 0; k < CBRT_STEPS; k++) begin : g_step
    localparam int SH = REM_W - 1 - 3 * k;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] y_in;
    logic [SQ_W-1:0]   sq_in;
    logic [BIG_W-1:0]  b;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = {{(REM_W-CONE_W-20){1'b0}}, acc, 20'd0};
      assign y_in   = '0;
      assign sq_in  = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign y_in   = y_q[k-1];
      assign sq_in  = sq_q[k-1];
    end

    // trial term 3y(y+1)+1 with y = 2Y: 12Y^2 + 6Y + 1
    assign b = ({4'd0, sq_in} << 3) + ({4'd0, sq_in} << 2)
             + ({{(BIG_W-ROOT_W){1'b0}}, y_in} << 2)
             + ({{(BIG_W-ROOT_W){1'b0}}, y_in} << 1) + BIG_W'(1);
    assign take = (rem_in >> SH) >= {{(REM_W-BIG_W){1'b0}}, b};

    always_ff @(posedge clk) begin
      if (en[2+k]) begin
        rem_q[k] <= take ? rem_in - ({{(REM_W-BIG_W){1'b0}}, b} << SH) : rem_in;
        y_q[k]   <= {y_in[ROOT_W-2:0], take};
        sq_q[k]  <= take ? (sq_in << 2) + ({{(SQ_W-ROOT_W){1'b0}}, y_in} << 2)
                           + SQ_W'(1)
                         : (sq_in << 2);
      end
    end
  end

  assign root = y_q[CBRT_STEPS-1];

endmodule

FILE: rtl/olab_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olab_merge
// Combine the three lane roots through the second matrix, round to
// 16 fraction bits and clamp to the output ranges.
// ----------------------------------------------------------------------------
module olab_merge (
  input  logic                         clk,
  input  logic [olab_pkg::ROOT_W-1:0]  root [3],
  input  logic [1:0]                   en,
  output logic [15:0]                  lightness,
  output logic signed [16:0]           green_red_axis,
  output logic signed [16:0]           blue_yellow_axis
);
  import olab_pkg::*;

  logic signed [LAB_PROD_W-1:0] prod [3][3];
  logic signed [LAB_SUM_W-1:0]  sum  [3];
  logic signed [RND_W-1:0]      rnd  [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= LAB_PROD_W'(LAB_COEF[i][j])
                      * LAB_PROD_W'($signed({1'b0, root[j]}));
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = LAB_SUM_W'(prod[i][0]) + LAB_SUM_W'(prod[i][1])
             + LAB_SUM_W'(prod[i][2]) + LAB_SUM_W'(1 << 19);
      rnd[i] = sum[i][LAB_SUM_W-1:20];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (rnd[0] < 0) begin
        lightness <= '0;
      end else if (rnd[0] > RND_W'(65535)) begin
        lightness <= 16'hFFFF;
      end else begin
        lightness <= rnd[0][15:0];
      end
      if (rnd[1] < -RND_W'(32768)) begin
        green_red_axis <= -17'sd32768;
      end else if (rnd[1] > RND_W'(32768)) begin
        green_red_axis <= 17'sd32768;
      end else begin
        green_red_axis <= rnd[1][16:0];
      end
      if (rnd[2] < -RND_W'(32768)) begin
        blue_yellow_axis <= -17'sd32768;
      end else if (rnd[2] > RND_W'(32768)) begin
        blue_yellow_axis <= 17'sd32768;
      end else begin
        blue_yellow_axis <= rnd[2][16:0];
      end
    end
  end

endmodule

FILE: tb/sv/linear_rgb_to_oklab_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_rgb_to_oklab_tb
// Self-checking bench for the linear RGB to OkLab pixel pipeline. Pixels are
// drawn from a queue, converted by a bit-exact predictor and compared field
// by field with every output transfer, under random idling on both sides.
// ----------------------------------------------------------------------------
module linear_rgb_to_oklab_tb;

  localparam int CB = olab_pkg::CHANNEL_BITS_DEF;
  localparam int PIPE_LAT = 27;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [15:0]        light;
    logic signed [16:0] axis_a;
    logic signed [16:0] axis_b;
  } lab_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] red_level = '0;
  logic [CB-1:0] green_level = '0;
  logic [CB-1:0] blue_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] lightness;
  logic signed [16:0] green_red_axis;
  logic signed [16:0] blue_yellow_axis;

  pixel_t pixel_q[$];
  lab_t   lab_expected_q[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     feed_done = 1'b0;
  bit     feed_hold = 1'b0;     // sender pause until the pipeline drains
  int     sink_hold_left = 0;   // receiver long hold-off, in cycles
  bit     idle_free = 1'b0;     // stretch with no random idling

  linear_rgb_to_oklab DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .red_level(red_level), .green_level(green_level), .blue_level(blue_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .lightness(lightness), .green_red_axis(green_red_axis),
    .blue_yellow_axis(blue_yellow_axis)
  );

  always #5 clk = ~clk;

  // Exact floor cube root, one result bit per step.
  function automatic logic [63:0] floor_cbrt(input logic [63:0] v);
    logic [63:0] y, rem, b;
    y = 0;
    rem = v;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((rem >> s) >= b) begin
        rem = rem - (b << s);
        y = y + 1;
      end
    end
    return y;
  endfunction

  function automatic lab_t convert_pixel(input pixel_t px);
    longint cone_k [3][3] = '{'{27015, 35149, 3372}, '{13887, 44610, 7038},
                              '{5787, 18463, 41286}};
    longint lab_k [3][3] = '{'{13792, 52011, -267}, '{129630, -159160, 29530},
                             '{1698, 51300, -52997}};
    longint full, ch[3], root[3], res[3], acc;
    lab_t r;
    full = (64'd1 << CB) - 1;
    ch[0] = ((longint'(px.red) << 24) + (full >> 1)) / full;
    ch[1] = ((longint'(px.green) << 24) + (full >> 1)) / full;
    ch[2] = ((longint'(px.blue) << 24) + (full >> 1)) / full;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += cone_k[i][j] * ch[j];
      root[i] = longint'(floor_cbrt(64'(acc) << 20));
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += lab_k[i][j] * root[j];
      res[i] = (acc + (64'sd1 << 19)) >>> 20;
    end
    r.light  = (res[0] < 0) ? 16'd0 : (res[0] > 65535) ? 16'd65535 : 16'(res[0]);
    r.axis_a = (res[1] < -32768) ? -17'sd32768 : (res[1] > 32768) ? 17'sd32768
             : 17'(res[1]);
    r.axis_b = (res[2] < -32768) ? -17'sd32768 : (res[2] > 32768) ? 17'sd32768
             : 17'(res[2]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic pixel_t mk(input int r, input int g, input int b);
    pixel_t p;
    p.red = CB'(r); p.green = CB'(g); p.blue = CB'(b);
    return p;
  endfunction

  // Driver: advance to the next pixel after each transfer, idle at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) lab_expected_q.push_back(convert_pixel({red_level, green_level,
                                                            blue_level}));
      if (pixel_q.size() > 0 && !feed_hold && (idle_free || $urandom_range(99) >= 24)) begin
        pixel_t p;
        p = pixel_q.pop_front();
        in_valid <= 1'b1;
        red_level <= p.red;
        green_level <= p.green;
        blue_level <= p.blue;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (lab_expected_q.size() == 0) begin
        report_mismatch("unexpected result", lightness, -1);
      end else begin
        lab_t e;
        e = lab_expected_q.pop_front();
        if (lightness !== e.light) report_mismatch("lightness", lightness, e.light);
        if (green_red_axis !== e.axis_a)
          report_mismatch("green_red_axis", green_red_axis, e.axis_a);
        if (blue_yellow_axis !== e.axis_b)
          report_mismatch("blue_yellow_axis", blue_yellow_axis, e.axis_b);
      end
    end
  end

  // Receiver stall: long hold-off when requested, else random idling.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (sink_hold_left > 0) begin
      out_stall <= 1'b1;
      sink_hold_left <= sink_hold_left - 1;
    end else begin
      out_stall <= !idle_free && ($urandom_range(99) < 24);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int rnd_channel();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      2: return $urandom_range(255);
      3: return 65535 - $urandom_range(255);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic wait_drained();
    while (pixel_q.size() > 0 || in_valid || lab_expected_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    bit failed;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: black, white, primaries, secondaries, extremes and single bits.
    pixel_q.push_back(mk(0, 0, 0));
    pixel_q.push_back(mk(65535, 65535, 65535));
    pixel_q.push_back(mk(65535, 0, 0));
    pixel_q.push_back(mk(0, 65535, 0));
    pixel_q.push_back(mk(0, 0, 65535));
    pixel_q.push_back(mk(65535, 65535, 0));
    pixel_q.push_back(mk(0, 65535, 65535));
    pixel_q.push_back(mk(65535, 0, 65535));
    pixel_q.push_back(mk(1, 1, 1));
    pixel_q.push_back(mk(1, 0, 0));
    pixel_q.push_back(mk(0, 0, 1));
    pixel_q.push_back(mk(32768, 32768, 32768));
    pixel_q.push_back(mk(32767, 32767, 32767));
    pixel_q.push_back(mk(21845, 43690, 21845));
    pixel_q.push_back(mk(43690, 21845, 43690));
    pixel_q.push_back(mk(65534, 65534, 65534));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering pixels.
    for (int i = 0; i < 60; i++) pixel_q.push_back(mk(rnd_channel(), rnd_channel(),
                                                      rnd_channel()));
    sink_hold_left = 120;
    wait_drained();

    // Burst with no idling on either side.
    idle_free = 1'b1;
    for (int i = 0; i < 80; i++) pixel_q.push_back(mk(rnd_channel(), rnd_channel(),
                                                      rnd_channel()));
    wait_drained();
    idle_free = 1'b0;

    // Random pixels, with a sender pause until the pipeline drains midway.
    for (int i = 0; i < 150; i++) pixel_q.push_back(mk(rnd_channel(), rnd_channel(),
                                                      rnd_channel()));
    while (pixel_q.size() > 75) @(posedge clk);
    feed_hold = 1'b1;
    while (in_valid || lab_expected_q.size() > 0) @(posedge clk);
    feed_hold = 1'b0;
    for (int i = 0; i < 160; i++) pixel_q.push_back(mk(rnd_channel(), rnd_channel(),
                                                      rnd_channel()));
    wait_drained();

    repeat (PIPE_LAT + 10) @(posedge clk);
    failed = (mismatch_count != 0) || (lab_expected_q.size() != 0);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
